FILE: src/hidrd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hidrd_pkg
// Shared types and constants of the HID report descriptor parser.
// ----------------------------------------------------------------------------
package hidrd_pkg;

  localparam int MaxRecords   = 16;
  localparam int MaxDepthBits = 8;
  localparam int RecIdxW      = $clog2(MaxRecords);
  localparam int RecCntW      = $clog2(MaxRecords + 1);
  localparam int CmdDepth     = 4;
  localparam int CmdIdxW      = $clog2(CmdDepth);

  // item type codes
  localparam logic [1:0] TypeMain     = 2'd0;
  localparam logic [1:0] TypeGlobal   = 2'd1;
  localparam logic [1:0] TypeLocal    = 2'd2;
  localparam logic [1:0] TypeReserved = 2'd3;

  // main tags
  localparam logic [3:0] TagInput   = 4'd8;
  localparam logic [3:0] TagOutput  = 4'd9;
  localparam logic [3:0] TagColl    = 4'd10;
  localparam logic [3:0] TagEndColl = 4'd12;
  // global tags
  localparam logic [3:0] TagUsagePage = 4'd0;
  localparam logic [3:0] TagLogMin    = 4'd1;
  localparam logic [3:0] TagLogMax    = 4'd2;
  localparam logic [3:0] TagRepSize   = 4'd7;
  localparam logic [3:0] TagRepId     = 4'd8;
  localparam logic [3:0] TagRepCount  = 4'd9;
  // local tags
  localparam logic [3:0] TagUsage    = 4'd0;
  localparam logic [3:0] TagUsageMin = 4'd1;
  localparam logic [3:0] TagUsageMax = 4'd2;

  // complete item handed from the byte front end to the executor
  typedef struct packed {
    logic        restart;
    logic [3:0]  tag;
    logic [1:0]  itype;
    logic [31:0] data;
  } item_t;

  typedef enum logic [1:0] {
    ST_EXEC,
    ST_MUL,
    ST_FLUSH
  } exec_state_t;

  function automatic logic [15:0] sat16(input logic [31:0] v);
    sat16 = (v[31:16] != 16'd0) ? 16'hFFFF : v[15:0];
  endfunction

endpackage

FILE: src/hid_report_descriptor_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hid_report_descriptor_parser
// USB HID report descriptor parser: byte stream in, field records out.
//
//   channel  direction  ports
//   input    in         in_push, in_full, in_data_byte, in_first_byte
//   result   out        out_empty, out_pop, out_report_id .. out_last
//
// One byte per cycle enters the front end while in_full is low; it gathers
// an item's data bytes. The executor retires most items directly; Input
// also passes ST_MUL (the size*count multiply is registered), an item that
// opens a new descriptor first clears state, and a flush sends one record
// whenever the output register is free. A four-entry queue decouples them;
// in_full rises only while it is full (mostly on a flush or out_pop stall).
// Reset is synchronous, rst_n low; all control state clears.
// ----------------------------------------------------------------------------
module hid_report_descriptor_parser
  import hidrd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_data_byte,
  input  logic        in_first_byte,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [7:0]  out_report_id,
  output logic [31:0] out_usage_page,
  output logic [31:0] out_usage,
  output logic [31:0] out_usage_min,
  output logic [31:0] out_usage_max,
  output logic [31:0] out_logical_min,
  output logic [31:0] out_logical_max,
  output logic [15:0] out_report_size,
  output logic [15:0] out_report_count,
  output logic [2:0]  out_flags,
  output logic [31:0] out_total_bits,
  output logic        out_last
);

  logic  item_valid, q_full, q_valid, q_pop, accept;
  item_t item, q_item;

  assign in_full = q_full;
  assign accept  = in_push && !q_full;

  hidrd_front u_front (
    .clk, .rst_n,
    .in_valid(accept), .in_data_byte, .in_first_byte,
    .item_valid, .item
  );

  hidrd_cmdq u_cmdq (
    .clk, .rst_n,
    .wr_en(item_valid), .wr_item(item), .full(q_full),
    .rd_en(q_pop), .rd_valid(q_valid), .rd_item(q_item)
  );

  hidrd_exec u_exec (
    .clk, .rst_n,
    .cmd_valid(q_valid), .cmd(q_item), .cmd_pop(q_pop),
    .out_empty, .out_pop, .out_report_id, .out_usage_page, .out_usage,
    .out_usage_min, .out_usage_max, .out_logical_min, .out_logical_max,
    .out_report_size, .out_report_count, .out_flags, .out_total_bits, .out_last
  );

endmodule

FILE: src/hidrd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hidrd_front
// Splits the byte stream into items: prefix decode and little-endian data
// gathering. Emits one complete item per finished item.
// ----------------------------------------------------------------------------
module hidrd_front
  import hidrd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic [7:0]  in_data_byte,
  input  logic        in_first_byte,
  output logic        item_valid,
  output item_t       item
);

  logic [7:0]  prefix_r,  prefix_nxt;
  logic [2:0]  left_r,    left_nxt;
  logic [31:0] accum_r,   accum_nxt;
  logic        restart_r, restart_nxt;
  logic [2:0]  len;
  logic [1:0]  pos;
  logic [2:0]  cur_left;

  always_comb begin
    prefix_nxt  = prefix_r;
    left_nxt    = left_r;
    accum_nxt   = accum_r;
    restart_nxt = restart_r;
    item_valid  = 1'b0;
    cur_left    = in_first_byte ? 3'd0 : left_r;
    len         = (prefix_r[1:0] == 2'd3) ? 3'd4 : {1'b0, prefix_r[1:0]};
    pos         = 2'(len - left_r);
    item.restart = in_first_byte | restart_r;
    item.tag     = prefix_r[7:4];
    item.itype   = prefix_r[3:2];
    item.data    = accum_r;
    if (in_valid) begin
      if (cur_left == 3'd0) begin
        prefix_nxt  = in_data_byte;
        accum_nxt   = 32'd0;
        left_nxt    = (in_data_byte[1:0] == 2'd3) ? 3'd4 : {1'b0, in_data_byte[1:0]};
        restart_nxt = in_first_byte;
        if (in_data_byte[1:0] == 2'd0) begin
          item_valid    = 1'b1;
          item.tag      = in_data_byte[7:4];
          item.itype    = in_data_byte[3:2];
          item.data     = 32'd0;
          item.restart  = in_first_byte;
          restart_nxt   = 1'b0;
        end
      end else begin
        accum_nxt = accum_r | ({24'd0, in_data_byte} << {pos, 3'b000});
        left_nxt  = left_r - 3'd1;
        if (left_r == 3'd1) begin
          item_valid  = 1'b1;
          item.data   = accum_nxt;
          restart_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r    <= 3'd0;
      restart_r <= 1'b0;
      prefix_r  <= 8'd0;
      accum_r   <= 32'd0;
    end else begin
      left_r    <= left_nxt;
      restart_r <= restart_nxt;
      prefix_r  <= prefix_nxt;
      accum_r   <= accum_nxt;
    end
  end

  a_left_range: assert property (@(posedge clk) disable iff (!rst_n) left_r <= 3'd4)
    else $error("bytes left out of range");
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_first_byte && left_r == 3'd1 |-> item_valid)
    else $error("last data byte gave no item");
  a_nodone: assert property (@(posedge clk) disable iff (!rst_n)
    !in_valid |-> !item_valid)
    else $error("item without a byte");

endmodule

FILE: src/hidrd_cmdq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hidrd_cmdq
// Short queue of decoded items between the front end and the executor.
// ----------------------------------------------------------------------------
module hidrd_cmdq
  import hidrd_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   wr_en,
  input  item_t  wr_item,
  output logic   full,
  input  logic   rd_en,
  output logic   rd_valid,
  output item_t  rd_item
);

  item_t             mem_r [CmdDepth];
  logic [CmdIdxW-1:0] wp_r, rp_r;
  logic [CmdIdxW:0]   cnt_r;

  assign full     = (cnt_r == (CmdIdxW+1)'(CmdDepth));
  assign rd_valid = (cnt_r != '0);
  assign rd_item  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= wp_r + 1'b1;
      if (rd_en) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (CmdIdxW+1)'(wr_en) - (CmdIdxW+1)'(rd_en);
    end
  end

  a_nooverflow: assert property (@(posedge clk) disable iff (!rst_n) full |-> !wr_en)
    else $error("item queue overflow");
  a_nounderflow: assert property (@(posedge clk) disable iff (!rst_n) !rd_valid |-> !rd_en)
    else $error("item queue underflow");
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (CmdIdxW+1)'(CmdDepth))
    else $error("item queue count out of range");

endmodule

FILE: src/hidrd_exec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hidrd_exec
// Executes items: global/local state, record buffer, bit total and
// flushes of buffered records on End Collection.
// ----------------------------------------------------------------------------
module hidrd_exec
  import hidrd_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cmd_valid,
  input  item_t        cmd,
  output logic         cmd_pop,
  output logic         out_empty,
  input  logic         out_pop,
  output logic [7:0]   out_report_id,
  output logic [31:0]  out_usage_page,
  output logic [31:0]  out_usage,
  output logic [31:0]  out_usage_min,
  output logic [31:0]  out_usage_max,
  output logic [31:0]  out_logical_min,
  output logic [31:0]  out_logical_max,
  output logic [15:0]  out_report_size,
  output logic [15:0]  out_report_count,
  output logic [2:0]   out_flags,
  output logic [31:0]  out_total_bits,
  output logic         out_last
);

  typedef struct packed {
    logic [31:0] page;
    logic [31:0] usage;
    logic [31:0] umin;
    logic [31:0] umax;
    logic [31:0] lmin;
    logic [31:0] lmax;
    logic [15:0] size;
    logic [15:0] count;
    logic [1:0]  flags;
  } rec_t;

  rec_t rec_mem [MaxRecords];

  exec_state_t state_r, state_nxt;
  logic [MaxDepthBits-1:0] depth_r, depth_nxt;
  logic [31:0] page_r, page_nxt, lmin_r, lmin_nxt, lmax_r, lmax_nxt;
  logic [31:0] umin_r, umin_nxt, umax_r, umax_nxt;
  logic [15:0] size_r, size_nxt, count_r, count_nxt;
  logic [31:0] fusage_r, fusage_nxt;
  logic        fvalid_r, fvalid_nxt;
  logic [7:0]  rid_r, rid_nxt;
  logic [31:0] total_r, total_nxt;
  logic [RecCntW-1:0] rcnt_r, rcnt_nxt;
  logic        ovf_r, ovf_nxt;
  logic [31:0] prod_r, prod_nxt;
  logic [RecIdxW-1:0] fidx_r, fidx_nxt;
  logic        rec_we;
  rec_t        rec_wdata;
  // restart of the head request already applied
  logic        rdone_r, rdone_nxt;
  logic        do_restart;
  // output register
  logic        ovalid_r, ovalid_nxt;
  logic        rd_en;
  rec_t        rd_r;
  logic        olast_r, olast_nxt, oovf_r, oovf_nxt;
  logic [32:0] sum;

  assign sum = {1'b0, total_r} + {1'b0, prod_r};

  always_comb begin
    state_nxt = state_r;
    depth_nxt = depth_r; page_nxt = page_r; lmin_nxt = lmin_r; lmax_nxt = lmax_r;
    umin_nxt = umin_r; umax_nxt = umax_r; size_nxt = size_r; count_nxt = count_r;
    fusage_nxt = fusage_r; fvalid_nxt = fvalid_r; rid_nxt = rid_r;
    total_nxt = total_r; rcnt_nxt = rcnt_r; ovf_nxt = ovf_r;
    prod_nxt = prod_r; fidx_nxt = fidx_r;
    ovalid_nxt = ovalid_r; olast_nxt = olast_r; oovf_nxt = oovf_r;
    rdone_nxt = rdone_r;
    do_restart = cmd_valid && cmd.restart && !rdone_r;
    cmd_pop = 1'b0; rec_we = 1'b0; rd_en = 1'b0;
    rec_wdata.page  = page_r;
    rec_wdata.usage = fvalid_r ? fusage_r : page_r;
    rec_wdata.umin  = umin_r;
    rec_wdata.umax  = umax_r;
    rec_wdata.lmin  = lmin_r;
    rec_wdata.lmax  = lmax_r;
    rec_wdata.size  = size_r;
    rec_wdata.count = count_r;
    rec_wdata.flags = cmd.data[1:0];
    if (ovalid_r && out_pop) ovalid_nxt = 1'b0;
    case (state_r)
      ST_EXEC: begin
        if (cmd_valid) begin
          if (do_restart) begin
            // restart clears all state, then the item runs next cycle
            depth_nxt = '0; page_nxt = '0; lmin_nxt = '0; lmax_nxt = '0;
            umin_nxt = '0; umax_nxt = '0; size_nxt = '0; count_nxt = '0;
            fusage_nxt = '0; fvalid_nxt = 1'b0; rid_nxt = '0; total_nxt = '0;
            rcnt_nxt = '0; ovf_nxt = 1'b0;
            rdone_nxt = 1'b1;
          end
          if (!do_restart && cmd.itype == TypeMain && cmd.tag == TagInput) begin
            prod_nxt  = 32'(size_r) * 32'(count_r);
            state_nxt = ST_MUL;
          end else if (!do_restart) begin
            cmd_pop = 1'b1;
            case (cmd.itype)
              TypeMain: begin
                if (cmd.tag == TagColl) begin
                  if (depth_r != {MaxDepthBits{1'b1}}) depth_nxt = depth_r + 1'b1;
                  rcnt_nxt = '0; ovf_nxt = 1'b0; fvalid_nxt = 1'b0; total_nxt = '0;
                end else if (cmd.tag == TagEndColl) begin
                  if (depth_r != '0) depth_nxt = depth_r - 1'b1;
                  if (total_r != 32'd0 && rcnt_r != '0) begin
                    cmd_pop   = 1'b0;
                    fidx_nxt  = '0;
                    state_nxt = ST_FLUSH;
                  end else begin
                    total_nxt = '0;
                  end
                end
              end
              TypeGlobal: begin
                case (cmd.tag)
                  TagUsagePage: page_nxt  = cmd.data;
                  TagLogMin:    lmin_nxt  = cmd.data;
                  TagLogMax:    lmax_nxt  = cmd.data;
                  TagRepSize:   size_nxt  = sat16(cmd.data);
                  TagRepId: begin
                    rid_nxt   = cmd.data[7:0];
                    total_nxt = '0;
                  end
                  TagRepCount:  count_nxt = sat16(cmd.data);
                  default: ;
                endcase
              end
              TypeLocal: begin
                case (cmd.tag)
                  TagUsage: begin
                    if (depth_r != '0 && !fvalid_r) begin
                      fvalid_nxt = 1'b1;
                      fusage_nxt = cmd.data;
                    end
                  end
                  TagUsageMin: umin_nxt = cmd.data;
                  TagUsageMax: umax_nxt = cmd.data;
                  default: ;
                endcase
              end
              default: ;
            endcase
          end
        end
      end
      ST_MUL: begin
        cmd_pop   = 1'b1;
        total_nxt = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        if (rcnt_r < RecCntW'(MaxRecords)) begin
          rec_we   = 1'b1;
          rcnt_nxt = rcnt_r + 1'b1;
        end else begin
          ovf_nxt = 1'b1;
        end
        fvalid_nxt = 1'b0;
        state_nxt  = ST_EXEC;
      end
      ST_FLUSH: begin
        // advance one record whenever the output register is free
        if (!ovalid_r || out_pop) begin
          rd_en      = 1'b1;
          ovalid_nxt = 1'b1;
          olast_nxt  = (RecCntW'(fidx_r) + 1'b1 == rcnt_r);
          oovf_nxt   = ovf_r && (RecCntW'(fidx_r) == RecCntW'(MaxRecords - 1));
          fidx_nxt   = fidx_r + 1'b1;
          if (olast_nxt) begin
            cmd_pop   = 1'b1;
            state_nxt = ST_EXEC;
          end
        end
      end
      default: state_nxt = ST_EXEC;
    endcase
    if (cmd_pop) rdone_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rec_we) rec_mem[rcnt_r[RecIdxW-1:0]] <= rec_wdata;
    if (rd_en) rd_r <= rec_mem[fidx_r];
  end

  // total is zeroed once the last record leaves; keep a copy for output
  logic [31:0] ototal_r, ototal_nxt;
  logic [7:0]  orid_r, orid_nxt;
  always_comb begin
    ototal_nxt = ototal_r;
    orid_nxt   = orid_r;
    if (rd_en) begin
      ototal_nxt = total_r;
      orid_nxt   = rid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_EXEC;
      depth_r <= '0; page_r <= '0; lmin_r <= '0; lmax_r <= '0;
      umin_r <= '0; umax_r <= '0; size_r <= '0; count_r <= '0;
      fusage_r <= '0; fvalid_r <= 1'b0; rid_r <= '0; total_r <= '0;
      rcnt_r <= '0; ovf_r <= 1'b0; ovalid_r <= 1'b0;
      olast_r <= 1'b0; oovf_r <= 1'b0; fidx_r <= '0; prod_r <= '0;
      ototal_r <= '0; orid_r <= '0; rdone_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      depth_r <= depth_nxt; page_r <= page_nxt; lmin_r <= lmin_nxt; lmax_r <= lmax_nxt;
      umin_r <= umin_nxt; umax_r <= umax_nxt; size_r <= size_nxt; count_r <= count_nxt;
      fusage_r <= fusage_nxt; fvalid_r <= fvalid_nxt; rid_r <= rid_nxt;
      total_r <= (state_r == ST_FLUSH && state_nxt == ST_EXEC) ? 32'd0 : total_nxt;
      rcnt_r <= rcnt_nxt; ovf_r <= ovf_nxt; ovalid_r <= ovalid_nxt;
      olast_r <= olast_nxt; oovf_r <= oovf_nxt; fidx_r <= fidx_nxt; prod_r <= prod_nxt;
      ototal_r <= ototal_nxt; orid_r <= orid_nxt; rdone_r <= rdone_nxt;
    end
  end

  assign out_empty        = !ovalid_r;
  assign out_report_id    = orid_r;
  assign out_usage_page   = rd_r.page;
  assign out_usage        = rd_r.usage;
  assign out_usage_min    = rd_r.umin;
  assign out_usage_max    = rd_r.umax;
  assign out_logical_min  = rd_r.lmin;
  assign out_logical_max  = rd_r.lmax;
  assign out_report_size  = rd_r.size;
  assign out_report_count = rd_r.count;
  assign out_flags        = {oovf_r, rd_r.flags};
  assign out_total_bits   = ototal_r;
  assign out_last         = olast_r;

  a_rcnt: assert property (@(posedge clk) disable iff (!rst_n)
    rcnt_r <= RecCntW'(MaxRecords))
    else $error("record count out of range");
  a_flush_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FLUSH |-> rcnt_r != '0 && total_r != 32'd0)
    else $error("flush with no records");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r && !out_pop |=> ovalid_r && $stable(rd_r))
    else $error("result changed while waiting");
  a_mul_pop: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_MUL |-> cmd_pop)
    else $error("input item not retired");

endmodule

FILE: tb/hidrd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hidrd_checker
// Watches the descriptor byte channel and the field record channel, runs a
// behavioral parser on every accepted byte and compares each popped record
// field by field against the oldest predicted one.
// ----------------------------------------------------------------------------
module hidrd_checker
  import hidrd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  input  logic        in_full,
  input  logic [7:0]  in_data_byte,
  input  logic        in_first_byte,
  input  logic        out_empty,
  input  logic        out_pop,
  input  logic [7:0]  out_report_id,
  input  logic [31:0] out_usage_page,
  input  logic [31:0] out_usage,
  input  logic [31:0] out_usage_min,
  input  logic [31:0] out_usage_max,
  input  logic [31:0] out_logical_min,
  input  logic [31:0] out_logical_max,
  input  logic [15:0] out_report_size,
  input  logic [15:0] out_report_count,
  input  logic [2:0]  out_flags,
  input  logic [31:0] out_total_bits,
  input  logic        out_last,
  output int          fail_count,
  output int          pending,
  output int          records_seen,
  output int          flushes_seen
);

  typedef struct packed {
    logic [7:0]  id8;
    logic [31:0] upage;
    logic [31:0] usage;
    logic [31:0] usage_min;
    logic [31:0] usage_max;
    logic [31:0] logical_min;
    logic [31:0] logical_max;
    logic [15:0] bit_size;
    logic [15:0] field_cnt;
    logic [2:0]  flags;
    logic [31:0] total_bits;
    logic        last;
  } field_rec_t;

  field_rec_t expected_recs[$];

  // parser state
  logic [7:0]  prefix;
  logic [2:0]  left;
  logic [31:0] accum;
  logic [MaxDepthBits-1:0] depth;
  logic [31:0] page, lmin, lmax, umin, umax;
  logic [15:0] rsize, rcount;
  logic        fu_valid;
  logic [31:0] fu_value;
  logic [7:0]  rep_id;
  logic [31:0] bits_sum;
  field_rec_t  stash[MaxRecords];
  int          stash_n;

  function automatic logic [15:0] clip16(input logic [31:0] v);
    return (v > 32'hFFFF) ? 16'hFFFF : v[15:0];
  endfunction

  task automatic restart_parser();
    prefix = '0; left = '0; accum = '0; depth = '0;
    page = '0; lmin = '0; lmax = '0; umin = '0; umax = '0;
    rsize = '0; rcount = '0; fu_valid = 1'b0; fu_value = '0;
    rep_id = '0; bits_sum = '0; stash_n = 0;
  endtask

  task automatic apply_item();
    logic [3:0]  tag;
    logic [1:0]  ity;
    logic [63:0] sum;
    field_rec_t  r;
    tag = prefix[7:4];
    ity = prefix[3:2];
    if (ity == TypeMain) begin
      if (tag == TagInput) begin
        sum = 64'(bits_sum) + 64'(rsize) * 64'(rcount);
        bits_sum = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
        if (stash_n < MaxRecords) begin
          r = '0;
          r.upage = page;
          r.usage = fu_valid ? fu_value : page;
          r.usage_min = umin;
          r.usage_max = umax;
          r.logical_min = lmin;
          r.logical_max = lmax;
          r.bit_size = rsize;
          r.field_cnt = rcount;
          r.flags = {1'b0, accum[1:0]};
          stash[stash_n] = r;
          stash_n++;
        end else begin
          stash[MaxRecords-1].flags[2] = 1'b1;
        end
        fu_valid = 1'b0;
      end else if (tag == TagColl) begin
        if (depth != '1) depth++;
        stash_n = 0; fu_valid = 1'b0; bits_sum = '0;
      end else if (tag == TagEndColl) begin
        if (depth != '0) depth--;
        if (bits_sum != 0 && stash_n > 0) begin
          for (int k = 0; k < stash_n; k++) begin
            r = stash[k];
            r.id8 = rep_id;
            r.total_bits = bits_sum;
            r.last = (k == stash_n - 1);
            expected_recs.insert(expected_recs.size(), r);
          end
          flushes_seen++;
        end
        bits_sum = '0;
      end
    end else if (ity == TypeGlobal) begin
      case (tag)
        TagUsagePage: page = accum;
        TagLogMin:    lmin = accum;
        TagLogMax:    lmax = accum;
        TagRepSize:   rsize = clip16(accum);
        TagRepId: begin
          rep_id = accum[7:0];
          bits_sum = '0;
        end
        TagRepCount:  rcount = clip16(accum);
        default: ;
      endcase
    end else if (ity == TypeLocal) begin
      if (tag == TagUsage) begin
        if (depth != 0 && !fu_valid) begin
          fu_valid = 1'b1;
          fu_value = accum;
        end
      end else if (tag == TagUsageMin) begin
        umin = accum;
      end else if (tag == TagUsageMax) begin
        umax = accum;
      end
    end
  endtask

  task automatic take_byte(input logic [7:0] b, input logic first);
    logic [2:0] len;
    if (first) restart_parser();
    if (left == 0) begin
      prefix = b;
      accum = '0;
      left = (b[1:0] == 2'd3) ? 3'd4 : {1'b0, b[1:0]};
      if (left == 0) apply_item();
    end else begin
      len = (prefix[1:0] == 2'd3) ? 3'd4 : {1'b0, prefix[1:0]};
      accum |= 32'(b) << (8 * ((len - left) & 3'd3));
      left--;
      if (left == 0) apply_item();
    end
  endtask

  task automatic check_rec();
    field_rec_t e;
    if (expected_recs.size() == 0) begin
      $error("record popped with none expected");
      fail_count++;
      return;
    end
    e = expected_recs.pop_front();
    records_seen++;
    if (out_report_id !== e.id8) begin
      $error("out_report_id exp %0h got %0h", e.id8, out_report_id); fail_count++;
    end
    if (out_usage_page !== e.upage) begin
      $error("out_usage_page exp %0h got %0h", e.upage, out_usage_page); fail_count++;
    end
    if (out_usage !== e.usage) begin
      $error("usage exp %0h got %0h", e.usage, out_usage); fail_count++;
    end
    if (out_usage_min !== e.usage_min) begin
      $error("usage_min exp %0h got %0h", e.usage_min, out_usage_min); fail_count++;
    end
    if (out_usage_max !== e.usage_max) begin
      $error("usage_max exp %0h got %0h", e.usage_max, out_usage_max); fail_count++;
    end
    if (out_logical_min !== e.logical_min) begin
      $error("logical_min exp %0h got %0h", e.logical_min, out_logical_min); fail_count++;
    end
    if (out_logical_max !== e.logical_max) begin
      $error("logical_max exp %0h got %0h", e.logical_max, out_logical_max); fail_count++;
    end
    if (out_report_size !== e.bit_size) begin
      $error("out_report_size exp %0h got %0h", e.bit_size, out_report_size);
      fail_count++;
    end
    if (out_report_count !== e.field_cnt) begin
      $error("out_report_count exp %0h got %0h", e.field_cnt, out_report_count);
      fail_count++;
    end
    if (out_flags !== e.flags) begin
      $error("flags exp %0h got %0h", e.flags, out_flags); fail_count++;
    end
    if (out_total_bits !== e.total_bits) begin
      $error("total_bits exp %0h got %0h", e.total_bits, out_total_bits); fail_count++;
    end
    if (out_last !== e.last) begin
      $error("last exp %0h got %0h", e.last, out_last); fail_count++;
    end
  endtask

  initial begin
    fail_count = 0;
    records_seen = 0;
    flushes_seen = 0;
    restart_parser();
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_push && !in_full) take_byte(in_data_byte, in_first_byte);
      if (out_pop && !out_empty) check_rec();
    end
    pending = expected_recs.size();
  end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Feeds the HID descriptor parser directed and random descriptor byte
// streams with random idling on both channels; a checker predicts records.
// ----------------------------------------------------------------------------
module testbench
  import hidrd_pkg::*;
();

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [7:0]  in_data_byte = '0;
  logic        in_first_byte = 1'b0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [7:0]  out_report_id;
  logic [31:0] out_usage_page, out_usage, out_usage_min, out_usage_max;
  logic [31:0] out_logical_min, out_logical_max, out_total_bits;
  logic [15:0] out_report_size, out_report_count;
  logic [2:0]  out_flags;
  logic        out_last;
  int          fail_count, pending, records_seen, flushes_seen;
  int          bytes_sent = 0;
  bit          sink_hold = 1'b0;
  bit          pop_random = 1'b1;

  always #5 clk = ~clk;

  hid_report_descriptor_parser dut (.*);

  hidrd_checker chk (.*);

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_byte(input logic [7:0] b, input bit first = 1'b0);
    int g;
    g = gap_len();
    repeat (g) @(negedge clk);
    in_push <= 1'b1;
    in_data_byte <= b;
    in_first_byte <= first;
    do @(posedge clk); while (in_full);
    bytes_sent++;
    @(negedge clk);
    in_push <= 1'b0;
    in_first_byte <= 1'b0;
  endtask

  // one short item: prefix then data bytes little-endian
  task automatic send_item(input logic [1:0] ity, input logic [3:0] tag,
                           input logic [1:0] sz, input logic [31:0] val);
    int n;
    n = (sz == 2'd3) ? 4 : sz;
    send_byte({tag, ity, sz});
    for (int i = 0; i < n; i++) send_byte(val[8*i +: 8]);
  endtask

  function automatic logic [31:0] rnd_val();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [1:0] rnd_sz();
    return 2'($urandom_range(0, 3));
  endfunction

  // well-formed collection with random fields; n_inputs may overflow buffer
  task automatic send_collection(input int n_inputs);
    send_item(TypeMain, TagColl, 2'd1, $urandom);
    for (int i = 0; i < n_inputs; i++) begin
      if ($urandom_range(0, 2) == 0) send_item(TypeGlobal, TagUsagePage, rnd_sz(), rnd_val());
      if ($urandom_range(0, 1)) send_item(TypeLocal, TagUsage, rnd_sz(), rnd_val());
      if ($urandom_range(0, 2) == 0) send_item(TypeLocal, TagUsage, rnd_sz(), rnd_val());
      if ($urandom_range(0, 2) == 0) send_item(TypeLocal, TagUsageMin, rnd_sz(), rnd_val());
      if ($urandom_range(0, 2) == 0) send_item(TypeLocal, TagUsageMax, rnd_sz(), rnd_val());
      if ($urandom_range(0, 2) == 0) send_item(TypeGlobal, TagLogMin, rnd_sz(), rnd_val());
      if ($urandom_range(0, 2) == 0) send_item(TypeGlobal, TagLogMax, rnd_sz(), rnd_val());
      if ($urandom_range(0, 1)) send_item(TypeGlobal, TagRepSize, 2'd1, $urandom_range(1, 16));
      if ($urandom_range(0, 1)) send_item(TypeGlobal, TagRepCount, 2'd1, $urandom_range(1, 8));
      if ($urandom_range(0, 9) == 0) send_item(TypeGlobal, TagRepId, rnd_sz(), rnd_val());
      send_item(TypeMain, TagInput, ($urandom_range(0, 7) == 0) ? 2'd0 : 2'd1, $urandom);
    end
    send_item(TypeMain, TagEndColl, 2'd0, 32'd0);
  endtask

  always @(negedge clk) begin
    if (sink_hold) out_pop <= 1'b0;
    else if (!pop_random) out_pop <= 1'b1;
    else out_pop <= ($urandom_range(0, 99) < 65);
  end

  initial begin
    #50ms;
    $display("FAILURE");
    $finish;
  end

  initial begin
    int guard;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: restart, extremes, every tag, overflow, saturation
    send_byte(8'h00, 1'b1);
    send_item(TypeMain, TagEndColl, 2'd0, 32'd0);
    send_item(TypeLocal, TagUsage, 2'd1, 32'h02);
    send_item(TypeMain, TagColl, 2'd0, 32'd0);
    send_item(TypeGlobal, TagRepSize, 2'd3, 32'h0001_0000);
    send_item(TypeGlobal, TagRepCount, 2'd3, 32'hFFFF_FFFF);
    send_item(TypeGlobal, TagRepId, 2'd2, 32'h1FF);
    send_item(TypeMain, TagInput, 2'd0, 32'd0);
    send_item(TypeMain, TagOutput, 2'd1, 32'hFF);
    send_item(TypeReserved, 4'hF, 2'd2, 32'hFFFF);
    send_item(TypeMain, TagEndColl, 2'd0, 32'd0);
    send_item(TypeMain, TagEndColl, 2'd0, 32'd0);
    send_collection(18);

    // hold the sink long enough for the block to back up
    sink_hold = 1'b1;
    fork
      begin
        repeat (400) @(negedge clk);
        sink_hold = 1'b0;
      end
      begin
        send_byte(8'h00, 1'b1);
        send_collection(16);
        send_collection(3);
      end
    join

    while (bytes_sent < 440) begin
      pop_random = ($urandom_range(0, 4) != 0);
      case ($urandom_range(0, 9))
        0: send_byte(8'($urandom), 1'($urandom_range(0, 1)));
        1: send_collection(6 + $urandom_range(0, 3));
        2: send_byte(8'h00, 1'b1);
        3: send_item(2'($urandom_range(0, 3)), 4'($urandom), rnd_sz(), $urandom);
        default: send_collection($urandom_range(1, 5));
      endcase
    end
    // close any open item and flush once more
    for (int i = 0; i < 4; i++) send_byte(8'h00);
    send_collection(2);
    pop_random = 1'b1;

    guard = 0;
    while (pending != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (60) @(posedge clk);
    $display("Sent %0d descriptor bytes; checked %0d records over %0d flushes.",
             bytes_sent, records_seen, flushes_seen);
    if (fail_count == 0 && pending == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

FILE: hid_report_descriptor_parser.f
src/hidrd_pkg.sv
src/hidrd_front.sv
src/hidrd_cmdq.sv
src/hidrd_exec.sv
src/hid_report_descriptor_parser.sv
tb/hidrd_checker.sv
tb/testbench.sv
